// File: src/rac_pkg.sv
package rac_pkg;

  localparam int RegsPerClass = 32;
  localparam int SpillSlots   = 256;
  localparam int IdxW         = $clog2(RegsPerClass);
  localparam int SlotW        = $clog2(SpillSlots);
  localparam int IdW          = 32;
  localparam int CmdW         = 3;
  localparam int ClsW         = 3;
  localparam int ErrW         = 3;

  localparam logic [CmdW-1:0] CMD_START  = 3'd0;
  localparam logic [CmdW-1:0] CMD_CHECK  = 3'd1;
  localparam logic [CmdW-1:0] CMD_SPILL  = 3'd2;
  localparam logic [CmdW-1:0] CMD_FILL   = 3'd3;
  localparam logic [CmdW-1:0] CMD_DEFINE = 3'd4;

  localparam logic [ClsW-1:0] CLS_GEN      = 3'd0;
  localparam logic [ClsW-1:0] CLS_FIX_GEN  = 3'd1;
  localparam logic [ClsW-1:0] CLS_FLOAT    = 3'd2;
  localparam logic [ClsW-1:0] CLS_FIX_FLT  = 3'd3;
  localparam logic [ClsW-1:0] CLS_GEN_PAIR = 3'd4;

  localparam logic [ErrW-1:0] ERR_OK     = 3'd0;
  localparam logic [ErrW-1:0] ERR_CLASS  = 3'd1;
  localparam logic [ErrW-1:0] ERR_PAIR   = 3'd2;
  localparam logic [ErrW-1:0] ERR_UNINIT = 3'd3;
  localparam logic [ErrW-1:0] ERR_WRONG  = 3'd4;
  localparam logic [ErrW-1:0] ERR_FILL   = 3'd5;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic             reg_valid;
    logic [ClsW-1:0]  reg_class;
    logic [IdxW-1:0]  reg_num;
    logic [IdW-1:0]   node_id;
    logic [SlotW-1:0] spill_slot;
  } in_item_t;

  typedef struct packed {
    logic [ErrW-1:0] error_code;
    logic [IdW-1:0]  found_id;
  } out_item_t;

  typedef struct packed {
    logic            en;
    logic            clear;
    logic [ClsW-1:0] cls;
    logic [IdxW-1:0] idx;
    logic [IdW-1:0]  id;
  } rf_wr_t;

  typedef struct packed {
    logic [IdW-1:0] gen_a;
    logic [IdW-1:0] gen_b;
    logic [IdW-1:0] fix_gen;
    logic [IdW-1:0] flt;
    logic [IdW-1:0] fix_flt;
  } rf_rd_t;

endpackage

// File: src/rac_ram.sv
module rac_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/rac_regfile.sv
module rac_regfile (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rac_pkg::rf_wr_t            wr,
  input  logic [rac_pkg::IdxW-1:0]   rd_idx,
  output rac_pkg::rf_rd_t            rd
);

  localparam int BankDepth = rac_pkg::RegsPerClass / 2;
  localparam int BankW     = rac_pkg::IdxW - 1;
  localparam int Regs      = rac_pkg::RegsPerClass;

  // general table split into even and odd banks so a pair reads one entry per bank
  logic [rac_pkg::IdW-1:0] gen_e_r   [BankDepth];
  logic [rac_pkg::IdW-1:0] gen_o_r   [BankDepth];
  logic [rac_pkg::IdW-1:0] fix_gen_r [Regs];
  logic [rac_pkg::IdW-1:0] flt_r     [Regs];
  logic [rac_pkg::IdW-1:0] fix_flt_r [Regs];
  logic [BankDepth-1:0]    gen_e_v_r;
  logic [BankDepth-1:0]    gen_o_v_r;
  logic [Regs-1:0]         fix_gen_v_r;
  logic [Regs-1:0]         flt_v_r;
  logic [Regs-1:0]         fix_flt_v_r;

  logic [rac_pkg::IdxW-1:0] wr_idx1;
  logic [BankW-1:0]         wr_e_addr;
  logic [BankW-1:0]         wr_o_addr;
  logic                     wr_e_en;
  logic                     wr_o_en;
  logic                     wr_fg_en;
  logic                     wr_fl_en;
  logic                     wr_ff_en;

  logic [rac_pkg::IdxW-1:0] rd_idx1;
  logic [BankW-1:0]         rd_e_addr;
  logic [BankW-1:0]         rd_o_addr;
  logic [rac_pkg::IdW-1:0]  rd_e;
  logic [rac_pkg::IdW-1:0]  rd_o;

  assign wr_idx1   = wr.idx + 1'b1;
  assign wr_o_addr = wr.idx[rac_pkg::IdxW-1:1];
  assign wr_e_addr = wr.idx[0] ? wr_idx1[rac_pkg::IdxW-1:1] : wr.idx[rac_pkg::IdxW-1:1];

  always_comb begin
    wr_e_en  = 1'b0;
    wr_o_en  = 1'b0;
    wr_fg_en = 1'b0;
    wr_fl_en = 1'b0;
    wr_ff_en = 1'b0;
    if (wr.en) begin
      case (wr.cls)
        rac_pkg::CLS_GEN: begin
          wr_e_en = ~wr.idx[0];
          wr_o_en = wr.idx[0];
        end
        rac_pkg::CLS_FIX_GEN: wr_fg_en = 1'b1;
        rac_pkg::CLS_FLOAT:   wr_fl_en = 1'b1;
        rac_pkg::CLS_FIX_FLT: wr_ff_en = 1'b1;
        rac_pkg::CLS_GEN_PAIR: begin
          wr_e_en = 1'b1;
          wr_o_en = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_e_en) begin
      gen_e_r[wr_e_addr] <= wr.id;
    end
    if (wr_o_en) begin
      gen_o_r[wr_o_addr] <= wr.id;
    end
    if (wr_fg_en) begin
      fix_gen_r[wr.idx] <= wr.id;
    end
    if (wr_fl_en) begin
      flt_r[wr.idx] <= wr.id;
    end
    if (wr_ff_en) begin
      fix_flt_r[wr.idx] <= wr.id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || wr.clear) begin
      gen_e_v_r   <= '0;
      gen_o_v_r   <= '0;
      fix_gen_v_r <= '0;
      flt_v_r     <= '0;
      fix_flt_v_r <= '0;
    end else begin
      if (wr_e_en) begin
        gen_e_v_r[wr_e_addr] <= 1'b1;
      end
      if (wr_o_en) begin
        gen_o_v_r[wr_o_addr] <= 1'b1;
      end
      if (wr_fg_en) begin
        fix_gen_v_r[wr.idx] <= 1'b1;
      end
      if (wr_fl_en) begin
        flt_v_r[wr.idx] <= 1'b1;
      end
      if (wr_ff_en) begin
        fix_flt_v_r[wr.idx] <= 1'b1;
      end
    end
  end

  assign rd_idx1   = rd_idx + 1'b1;
  assign rd_o_addr = rd_idx[rac_pkg::IdxW-1:1];
  assign rd_e_addr = rd_idx[0] ? rd_idx1[rac_pkg::IdxW-1:1] : rd_idx[rac_pkg::IdxW-1:1];

  assign rd_e = gen_e_v_r[rd_e_addr] ? gen_e_r[rd_e_addr] : '0;
  assign rd_o = gen_o_v_r[rd_o_addr] ? gen_o_r[rd_o_addr] : '0;

  assign rd.gen_a   = rd_idx[0] ? rd_o : rd_e;
  assign rd.gen_b   = rd_idx[0] ? rd_e : rd_o;
  assign rd.fix_gen = fix_gen_v_r[rd_idx] ? fix_gen_r[rd_idx] : '0;
  assign rd.flt     = flt_v_r[rd_idx] ? flt_r[rd_idx] : '0;
  assign rd.fix_flt = fix_flt_v_r[rd_idx] ? fix_flt_r[rd_idx] : '0;

endmodule

// File: src/register_allocation_checker_core.sv
// Register allocation checker: shadow register file for an allocation trace.
// Input channel in_valid/in_stall/in_data carries one trace event per
// transaction (block start, check, spill, fill, define). Result channel
// out_valid/out_stall/out_data returns one error code and found id per event,
// in order.
// An accepted event is registered in the evaluation stage; its result is
// registered onto out_data when that stage fires. Throughput: one event per
// cycle while the output is not stalled; the register tables are flops
// read and written within the evaluation stage, and the spill-slot memory
// is read as the event is accepted, with a bypass from a spill still in the
// evaluation stage.
// Reset: empties all register tables and slot valid bits and drops any
// transaction in flight. Slot contents are not cleared; only valid slots
// are ever read.
// Stall: a stalled result holds on out_data; one more event sits in the
// evaluation stage, after which in_stall rises until the result is taken.
module register_allocation_checker_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rac_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rac_pkg::out_item_t out_data
);

  rac_pkg::in_item_t  st_r;
  logic               st_vld_r;
  logic               fwd_r;
  logic [rac_pkg::IdW-1:0] fwd_id_r;
  logic [rac_pkg::SpillSlots-1:0] slot_vld_r;
  rac_pkg::out_item_t out_r;
  logic               out_vld_r;

  logic               accept;
  logic               st_fire;
  logic               st_spill;
  logic               st_start;
  rac_pkg::rf_wr_t    rf_wr;
  rac_pkg::rf_rd_t    rf_rd;
  logic [rac_pkg::IdW-1:0] ram_q;
  logic [rac_pkg::IdW-1:0] slot_id;
  logic [rac_pkg::IdW-1:0] reg_v;
  rac_pkg::out_item_t chk;
  rac_pkg::out_item_t res_nxt;

  assign st_fire  = st_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall = st_vld_r & ~st_fire;
  assign accept   = in_valid & ~in_stall;
  assign st_spill = st_fire & (st_r.cmd == rac_pkg::CMD_SPILL);
  assign st_start = st_fire & (st_r.cmd == rac_pkg::CMD_START);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r <= 1'b0;
    end else if (accept) begin
      st_vld_r <= 1'b1;
    end else if (st_fire) begin
      st_vld_r <= 1'b0;
    end
  end

  // slot write in the same cycle as the read needs bypassing
  always_ff @(posedge clk) begin
    if (accept) begin
      st_r     <= in_data;
      fwd_r    <= st_spill & (st_r.spill_slot == in_data.spill_slot);
      fwd_id_r <= st_r.node_id;
    end
  end

  rac_ram #(
    .Width (rac_pkg::IdW),
    .Depth (rac_pkg::SpillSlots)
  ) u_slot_ram (
    .clk   (clk),
    .we    (st_spill),
    .waddr (st_r.spill_slot),
    .wdata (st_r.node_id),
    .re    (accept),
    .raddr (in_data.spill_slot),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n || st_start) begin
      slot_vld_r <= '0;
    end else if (st_spill) begin
      slot_vld_r[st_r.spill_slot] <= 1'b1;
    end
  end

  assign slot_id = fwd_r ? fwd_id_r : ram_q;

  always_comb begin
    rf_wr.clear = st_start;
    rf_wr.en    = st_fire & st_r.reg_valid &
                  ((st_r.cmd == rac_pkg::CMD_FILL) || (st_r.cmd == rac_pkg::CMD_DEFINE));
    rf_wr.cls   = st_r.reg_class;
    rf_wr.idx   = st_r.reg_num;
    rf_wr.id    = st_r.node_id;
  end

  rac_regfile u_regfile (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (rf_wr),
    .rd_idx (st_r.reg_num),
    .rd     (rf_rd)
  );

  always_comb begin
    reg_v = '0;
    chk   = '{error_code: rac_pkg::ERR_OK, found_id: '0};
    case (st_r.reg_class)
      rac_pkg::CLS_GEN:      reg_v = rf_rd.gen_a;
      rac_pkg::CLS_FIX_GEN:  reg_v = rf_rd.fix_gen;
      rac_pkg::CLS_FLOAT:    reg_v = rf_rd.flt;
      rac_pkg::CLS_FIX_FLT:  reg_v = rf_rd.fix_flt;
      rac_pkg::CLS_GEN_PAIR: reg_v = rf_rd.gen_a;
      default:               reg_v = '0;
    endcase
    if (st_r.reg_class > rac_pkg::CLS_GEN_PAIR) begin
      chk.error_code = rac_pkg::ERR_CLASS;
    end else if ((st_r.reg_class == rac_pkg::CLS_GEN_PAIR) && (rf_rd.gen_a != rf_rd.gen_b)) begin
      chk.error_code = rac_pkg::ERR_PAIR;
      chk.found_id   = reg_v;
    end else begin
      chk.found_id = reg_v;
      if (reg_v == '0) begin
        chk.error_code = rac_pkg::ERR_UNINIT;
      end else if (reg_v != st_r.node_id) begin
        chk.error_code = rac_pkg::ERR_WRONG;
      end
    end
  end

  always_comb begin
    res_nxt = '{error_code: rac_pkg::ERR_OK, found_id: '0};
    case (st_r.cmd)
      rac_pkg::CMD_CHECK,
      rac_pkg::CMD_SPILL: begin
        if (st_r.reg_valid) begin
          res_nxt = chk;
        end
      end
      rac_pkg::CMD_FILL: begin
        if (!slot_vld_r[st_r.spill_slot] || (slot_id == '0)) begin
          res_nxt.error_code = rac_pkg::ERR_FILL;
        end else begin
          res_nxt.found_id = slot_id;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (st_fire) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_fire) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// File: verif/register_allocation_checker_core_tb.sv
module register_allocation_checker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rac_pkg::*;

  localparam logic [CmdW-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CmdW-1:0] CMD_SPARE_MID   = 3'd6;
  localparam logic [CmdW-1:0] CMD_SPARE_LAST  = 3'd7;
  localparam logic [ClsW-1:0] CLS_SPARE_FIRST = 3'd5;
  localparam logic [ClsW-1:0] CLS_SPARE_MID   = 3'd6;
  localparam logic [ClsW-1:0] CLS_SPARE_LAST  = 3'd7;
  localparam logic [IdW-1:0]  ID_ALL_ONES     = 32'hffff_ffff;
  localparam logic [IdW-1:0]  ID_TOP_EVEN     = 32'hffff_fffe;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  register_allocation_checker_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // shadow copy of the register tables and spill slots
  logic [IdW-1:0] reg_ids [4][RegsPerClass];
  logic [IdW-1:0] slot_ids [SpillSlots];
  logic           slot_full [SpillSlots];

  out_item_t pending_results[$];
  int        send_gap_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_req = 0;
  int        hold_left = 0;
  int        events_sent = 0;
  int        results_checked = 0;
  int        mismatches = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("[register_allocation_checker_core] ERROR");
    $finish;
  end

  function automatic void clear_tables();
    foreach (reg_ids[c, r]) reg_ids[c][r] = '0;
    foreach (slot_full[s]) slot_full[s] = 1'b0;
  endfunction

  function automatic void lookup_register(input logic [ClsW-1:0] cls,
                                          input logic [IdxW-1:0] num,
                                          input logic [IdW-1:0] want,
                                          output logic [ErrW-1:0] err,
                                          output logic [IdW-1:0] found);
    logic [IdxW-1:0] upper;
    logic [IdW-1:0]  held;
    upper = num + 1'b1;
    err = ERR_OK;
    found = '0;
    if (cls == CLS_GEN_PAIR) begin
      held = reg_ids[CLS_GEN][num];
      if (held != reg_ids[CLS_GEN][upper]) begin
        err = ERR_PAIR;
        found = held;
        return;
      end
    end else if (cls > CLS_FIX_FLT) begin
      err = ERR_CLASS;
      return;
    end else begin
      held = reg_ids[cls[1:0]][num];
    end
    found = held;
    if (held == '0) err = ERR_UNINIT;
    else if (held != want) err = ERR_WRONG;
  endfunction

  function automatic void write_register(input logic [ClsW-1:0] cls,
                                         input logic [IdxW-1:0] num,
                                         input logic [IdW-1:0] id);
    logic [IdxW-1:0] upper;
    upper = num + 1'b1;
    if (cls == CLS_GEN_PAIR) begin
      reg_ids[CLS_GEN][num] = id;
      reg_ids[CLS_GEN][upper] = id;
    end else if (cls <= CLS_FIX_FLT) begin
      reg_ids[cls[1:0]][num] = id;
    end
  endfunction

  function automatic out_item_t apply_event(input in_item_t ev);
    out_item_t      res;
    logic [ErrW-1:0] err;
    logic [IdW-1:0]  found;
    err = ERR_OK;
    found = '0;
    case (ev.cmd)
      CMD_START: clear_tables();
      CMD_CHECK: begin
        if (ev.reg_valid) lookup_register(ev.reg_class, ev.reg_num, ev.node_id, err, found);
      end
      CMD_SPILL: begin
        if (ev.reg_valid) lookup_register(ev.reg_class, ev.reg_num, ev.node_id, err, found);
        slot_ids[ev.spill_slot] = ev.node_id;
        slot_full[ev.spill_slot] = 1'b1;
      end
      CMD_FILL: begin
        if (!slot_full[ev.spill_slot] || slot_ids[ev.spill_slot] == '0) err = ERR_FILL;
        else found = slot_ids[ev.spill_slot];
        if (ev.reg_valid) write_register(ev.reg_class, ev.reg_num, ev.node_id);
      end
      CMD_DEFINE: begin
        if (ev.reg_valid) write_register(ev.reg_class, ev.reg_num, ev.node_id);
      end
      default: ;
    endcase
    res.error_code = err;
    res.found_id = found;
    return res;
  endfunction

  function automatic in_item_t trace_event(input logic [CmdW-1:0] cmd, input logic rv,
                                           input logic [ClsW-1:0] cls,
                                           input logic [IdxW-1:0] num,
                                           input logic [IdW-1:0] id,
                                           input logic [SlotW-1:0] slot);
    in_item_t ev;
    ev.cmd = cmd;
    ev.reg_valid = rv;
    ev.reg_class = cls;
    ev.reg_num = num;
    ev.node_id = id;
    ev.spill_slot = slot;
    return ev;
  endfunction

  // mostly coherent trace: checks and spills usually name the id the register holds
  function automatic in_item_t random_trace_event();
    in_item_t       ev;
    int unsigned    pick;
    logic [IdW-1:0] held;
    pick = $urandom_range(99);
    if (pick < 2) ev.cmd = CMD_START;
    else if (pick < 30) ev.cmd = CMD_CHECK;
    else if (pick < 45) ev.cmd = CMD_SPILL;
    else if (pick < 60) ev.cmd = CMD_FILL;
    else if (pick < 95) ev.cmd = CMD_DEFINE;
    else ev.cmd = CmdW'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
    ev.reg_valid = ($urandom_range(99) < 90);
    if ($urandom_range(99) < 88) ev.reg_class = ClsW'($urandom_range(CLS_GEN, CLS_GEN_PAIR));
    else ev.reg_class = ClsW'($urandom_range(CLS_SPARE_FIRST, CLS_SPARE_LAST));
    ev.reg_num = $urandom_range(1) ? IdxW'($urandom_range(7))
                                   : IdxW'($urandom_range(RegsPerClass - 1));
    ev.spill_slot = ($urandom_range(99) < 60) ? SlotW'($urandom_range(15))
                                              : SlotW'($urandom_range(SpillSlots - 1));
    pick = $urandom_range(99);
    if (pick < 40) ev.node_id = $urandom_range(1, 16);
    else if (pick < 44) ev.node_id = '0;
    else if (pick < 48) ev.node_id = ID_ALL_ONES;
    else if (pick < 52) ev.node_id = ID_TOP_EVEN;
    else ev.node_id = $urandom;
    if ((ev.cmd == CMD_CHECK || ev.cmd == CMD_SPILL) && $urandom_range(99) < 60) begin
      if (ev.reg_class == CLS_GEN_PAIR) held = reg_ids[CLS_GEN][ev.reg_num];
      else if (ev.reg_class <= CLS_FIX_FLT) held = reg_ids[ev.reg_class[1:0]][ev.reg_num];
      else held = '0;
      if (held != '0) ev.node_id = held;
    end
    return ev;
  endfunction

  task automatic issue_event(input in_item_t ev);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= ev;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_event(ev));
    events_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction, error_code %0d found_id %h", $time,
                 out_data.error_code, out_data.found_id);
      end else begin
        want = pending_results.pop_front();
        if (out_data.error_code !== want.error_code) begin
          mismatches++;
          $display("%0t: error_code expected %0d actual %0d", $time, want.error_code,
                   out_data.error_code);
        end
        if (out_data.found_id !== want.found_id) begin
          mismatches++;
          $display("%0t: found_id expected %h actual %h", $time, want.found_id,
                   out_data.found_id);
        end
      end
    end
  end

  task automatic test_directed();
    send_gap_pct = 0;
    recv_stall_pct = 0;
    issue_event(trace_event(CMD_START, 1'b1, CLS_GEN, 5'd0, 32'd1, 8'd0));
    issue_event(trace_event(CMD_CHECK, 1'b1, CLS_GEN, 5'd0, 32'd5, 8'd0));
    issue_event(trace_event(CMD_DEFINE, 1'b1, CLS_GEN, 5'd0, ID_ALL_ONES, 8'd0));
    issue_event(trace_event(CMD_CHECK, 1'b1, CLS_GEN, 5'd0, ID_ALL_ONES, 8'd0));
    issue_event(trace_event(CMD_CHECK, 1'b1, CLS_GEN, 5'd0, ID_TOP_EVEN, 8'd0));
    issue_event(trace_event(CMD_DEFINE, 1'b1, CLS_FIX_GEN, 5'd31, ID_TOP_EVEN, 8'd0));
    issue_event(trace_event(CMD_CHECK, 1'b1, CLS_FIX_GEN, 5'd31, ID_TOP_EVEN, 8'd0));
    issue_event(trace_event(CMD_DEFINE, 1'b1, CLS_FIX_FLT, 5'd3, 32'haaaa_5555, 8'd0));
    issue_event(trace_event(CMD_CHECK, 1'b1, CLS_FIX_FLT, 5'd3, 32'h5555_aaaa, 8'd0));
    // pair at the top register wraps onto general 0
    issue_event(trace_event(CMD_DEFINE, 1'b1, CLS_GEN_PAIR, 5'd31, 32'd77, 8'd0));
    issue_event(trace_event(CMD_CHECK, 1'b1, CLS_GEN_PAIR, 5'd31, 32'd77, 8'd0));
    issue_event(trace_event(CMD_CHECK, 1'b1, CLS_GEN_PAIR, 5'd30, 32'd77, 8'd0));
    issue_event(trace_event(CMD_DEFINE, 1'b1, CLS_SPARE_FIRST, 5'd2, 32'd9, 8'd0));
    issue_event(trace_event(CMD_CHECK, 1'b1, CLS_SPARE_MID, 5'd2, 32'd9, 8'd0));
    issue_event(trace_event(CMD_CHECK, 1'b0, CLS_GEN, 5'd0, 32'd3, 8'd0));
    issue_event(trace_event(CMD_SPILL, 1'b1, CLS_GEN, 5'd0, 32'd77, 8'd255));
    issue_event(trace_event(CMD_FILL, 1'b1, CLS_FLOAT, 5'd0, 32'd123, 8'd255));
    issue_event(trace_event(CMD_CHECK, 1'b1, CLS_FLOAT, 5'd0, 32'd123, 8'd0));
    issue_event(trace_event(CMD_FILL, 1'b0, CLS_GEN, 5'd0, 32'd1, 8'd0));
    // a spill of id zero leaves the slot reading as empty
    issue_event(trace_event(CMD_SPILL, 1'b1, CLS_SPARE_LAST, 5'd0, 32'd0, 8'd0));
    issue_event(trace_event(CMD_FILL, 1'b1, CLS_GEN, 5'd5, 32'd0, 8'd0));
    issue_event(trace_event(CMD_CHECK, 1'b1, CLS_GEN, 5'd5, 32'd0, 8'd0));
    issue_event(trace_event(CMD_SPARE_FIRST, 1'b1, CLS_GEN, 5'd0, 32'd1, 8'd1));
    issue_event(trace_event(CMD_SPARE_MID, 1'b1, CLS_GEN, 5'd0, 32'd1, 8'd1));
    issue_event(trace_event(CMD_SPARE_LAST, 1'b1, CLS_GEN, 5'd0, 32'd1, 8'd1));
    issue_event(trace_event(CMD_START, 1'b0, CLS_GEN, 5'd0, 32'd1, 8'd0));
    issue_event(trace_event(CMD_FILL, 1'b1, CLS_GEN, 5'd1, 32'd4, 8'd255));
    wait_drain();
  endtask

  task automatic test_random_traffic(input int count, input int gap_pct, input int stall_pct);
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    repeat (count) issue_event(random_trace_event());
  endtask

  task automatic test_backpressure();
    send_gap_pct = 0;
    recv_stall_pct = 0;
    hold_req = 60;
    repeat (24) issue_event(random_trace_event());
    wait_drain();
  endtask

  task automatic test_sender_pause();
    send_gap_pct = 0;
    recv_stall_pct = 30;
    repeat (12) issue_event(random_trace_event());
    wait_drain();
    repeat (12) issue_event(random_trace_event());
  endtask

  initial begin
    clear_tables();
    foreach (slot_ids[s]) slot_ids[s] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_traffic(600, 13, 70);
    test_random_traffic(600, 70, 13);
    test_random_traffic(600, 0, 0);
    test_backpressure();
    test_sender_pause();
    wait_drain();
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    $display("Sent %0d trace events and compared %0d results across every command and class,",
             events_sent, results_checked);
    $display("with input gaps, output stalls, a long output hold-off and a drained pause.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[register_allocation_checker_core] OK");
    end else begin
      $display("[register_allocation_checker_core] ERROR");
    end
    $finish;
  end

endmodule
